/* src/lpg_pkg.sv */
`default_nettype none

package lpg_pkg;

  // PWM compare level at full brightness
  localparam logic [9:0] PwmTop = 10'd999;

  // Breathing ramp: one half of the mirrored curve
  localparam int unsigned RampEntries = 150;
  localparam int unsigned RampIdxW    = $clog2(RampEntries);
  localparam int unsigned PhaseW      = $clog2(2 * RampEntries);

  localparam logic [PhaseW-1:0] PhaseLast = PhaseW'(2 * RampEntries - 1);
  localparam logic [PhaseW-1:0] RampLast  = PhaseW'(RampEntries - 1);

  // Pattern timings in microseconds
  localparam logic [31:0] TBlink   = 32'd500000;
  localparam logic [31:0] TFast    = 32'd150000;
  localparam logic [31:0] TDpOn    = 32'd100000;
  localparam logic [31:0] TDpGap   = 32'd100000;
  localparam logic [31:0] TDpPause = 32'd700000;
  localparam logic [31:0] TCnOn    = 32'd100000;
  localparam logic [31:0] TCnGap   = 32'd100000;
  localparam logic [31:0] TCnPause = 32'd400000;
  localparam logic [31:0] TSpOn    = 32'd200000;
  localparam logic [31:0] TSpOff   = 32'd1500000;
  localparam logic [31:0] TSlOn    = 32'd150000;
  localparam logic [31:0] TSlOff   = 32'd3000000;

  typedef enum logic [3:0] {
    MODE_OFF        = 4'd0,
    MODE_ON         = 4'd1,
    MODE_BLINK      = 4'd2,
    MODE_FAST       = 4'd3,
    MODE_DOUBLE     = 4'd4,
    MODE_CONNECTING = 4'd5,
    MODE_BREATHE    = 4'd6,
    MODE_SLOW       = 4'd7,
    MODE_SLOWER     = 4'd8
  } mode_e;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_SET    = 1'b1
  } op_e;

  typedef struct packed {
    logic        op;
    logic [3:0]  new_mode;
    logic [31:0] now_us;
  } lpg_in_t;

  typedef struct packed {
    logic [9:0] level;
    logic       lit;
  } lpg_out_t;

  localparam logic [9:0] RampRom [RampEntries] = '{
    10'd0,   10'd0,   10'd0,   10'd1,   10'd1,   10'd2,   10'd2,   10'd3,   10'd4,   10'd6,
    10'd7,   10'd9,   10'd11,  10'd13,  10'd15,  10'd17,  10'd20,  10'd22,  10'd25,  10'd29,
    10'd32,  10'd36,  10'd39,  10'd43,  10'd47,  10'd52,  10'd56,  10'd61,  10'd66,  10'd71,
    10'd77,  10'd82,  10'd88,  10'd94,  10'd100, 10'd106, 10'd112, 10'd119, 10'd126, 10'd133,
    10'd140, 10'd147, 10'd155, 10'd162, 10'd170, 10'd178, 10'd186, 10'd195, 10'd203, 10'd212,
    10'd220, 10'd229, 10'd238, 10'd247, 10'd257, 10'd266, 10'd275, 10'd285, 10'd295, 10'd304,
    10'd314, 10'd324, 10'd334, 10'd345, 10'd355, 10'd365, 10'd376, 10'd386, 10'd397, 10'd407,
    10'd418, 10'd428, 10'd439, 10'd450, 10'd461, 10'd471, 10'd482, 10'd493, 10'd504, 10'd515,
    10'd526, 10'd537, 10'd547, 10'd558, 10'd569, 10'd580, 10'd591, 10'd601, 10'd612, 10'd622,
    10'd633, 10'd644, 10'd654, 10'd664, 10'd675, 10'd685, 10'd695, 10'd705, 10'd715, 10'd725,
    10'd734, 10'd744, 10'd754, 10'd763, 10'd772, 10'd781, 10'd790, 10'd799, 10'd808, 10'd817,
    10'd825, 10'd833, 10'd841, 10'd849, 10'd857, 10'd865, 10'd872, 10'd879, 10'd886, 10'd893,
    10'd900, 10'd906, 10'd913, 10'd919, 10'd925, 10'd930, 10'd936, 10'd941, 10'd946, 10'd951,
    10'd956, 10'd960, 10'd964, 10'd968, 10'd972, 10'd975, 10'd979, 10'd982, 10'd984, 10'd987,
    10'd989, 10'd991, 10'd993, 10'd995, 10'd996, 10'd997, 10'd998, 10'd999, 10'd999, 10'd999
  };

  // Look up the ramp, clamping past the last entry
  function automatic logic [9:0] ramp_lookup(logic [PhaseW-1:0] idx);
    logic [PhaseW-1:0] k;
    k = (idx > RampLast) ? RampLast : idx;
    return RampRom[k[RampIdxW-1:0]];
  endfunction

endpackage

`default_nettype wire

/* src/led_pattern_generator.sv */
// LED pattern generator: computes the PWM compare level and on/off state of
// one status LED from a stream of timestamped items.
// Input channel (in_valid_i / in_stall_o / in_data_i): each transfer is a
// mode change (op set) or an update event, stamped with a microsecond time.
// Output channel (out_valid_o / out_stall_i / out_data_o): exactly one
// result per input transfer, in order: level (0..999) and lit.
// Each item is held in the input register; its result is then loaded into
// the result register and transfers when the receiver does not stall.
// Throughput: one item per cycle while the receiver does not stall; the
// pattern state updates as an item moves into the result register.
// Receiver stall: the result register holds its payload; the input register
// still takes one more item, then in_stall_o rises until the result moves.
// Reset: both registers empty, mode off, LED dark, level 0, all timers and
// the breathing phase cleared.
`default_nettype none

module led_pattern_generator import lpg_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire lpg_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output lpg_out_t      out_data_o
);

  logic     in_valid_q;
  lpg_in_t  in_data_q;
  logic     out_valid_q;
  lpg_out_t out_data_q;
  lpg_out_t result;
  logic     advance;

  // Move the held item into the result register when that slot frees up
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  lpg_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (in_data_q),
    .result_o  (result)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

/* src/lpg_core.sv */
`default_nettype none

module lpg_core import lpg_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_en_i,
  input  wire lpg_in_t  item_i,
  output lpg_out_t      result_o
);

  logic [3:0]        mode_q,   mode_d;
  logic              lit_q,    lit_d;
  logic [31:0]       toggle_q, toggle_d;
  logic [1:0]        step_q,   step_d;
  logic [PhaseW-1:0] phase_q,  phase_d;
  logic [9:0]        level_q,  level_d;

  logic [31:0]       elapsed;
  logic [31:0]       pat_on, pat_gap, pat_pause, pat_limit, tog_limit;
  logic              is_pattern, is_toggle;
  logic [PhaseW-1:0] ramp_idx;

  assign elapsed = item_i.now_us - toggle_q;

  // Select pattern timings for the four-step modes
  always_comb begin
    if (mode_q == MODE_DOUBLE) begin
      pat_on = TDpOn; pat_gap = TDpGap; pat_pause = TDpPause;
    end else begin
      pat_on = TCnOn; pat_gap = TCnGap; pat_pause = TCnPause;
    end
    case (step_q)
      2'd1:    pat_limit = pat_gap;
      2'd3:    pat_limit = pat_pause;
      default: pat_limit = pat_on;
    endcase
  end

  // Select the toggle threshold for the two-phase modes
  always_comb begin
    is_toggle = 1'b1;
    is_pattern = 1'b0;
    tog_limit = TBlink;
    case (mode_q)
      MODE_BLINK:  tog_limit = TBlink;
      MODE_FAST:   tog_limit = TFast;
      MODE_SLOW:   tog_limit = lit_q ? TSpOn : TSpOff;
      MODE_SLOWER: tog_limit = lit_q ? TSlOn : TSlOff;
      MODE_DOUBLE, MODE_CONNECTING: begin
        is_toggle = 1'b0;
        is_pattern = 1'b1;
      end
      default: is_toggle = 1'b0;
    endcase
  end

  assign ramp_idx = (phase_q <= RampLast) ? phase_q : PhaseLast - phase_q;

  // Next state for the item in the input register
  always_comb begin
    mode_d   = mode_q;
    lit_d    = lit_q;
    toggle_d = toggle_q;
    step_d   = step_q;
    phase_d  = phase_q;
    level_d  = level_q;
    if (item_i.op == OP_SET) begin
      mode_d  = item_i.new_mode;
      step_d  = '0;
      phase_d = '0;
      case (item_i.new_mode)
        MODE_OFF: begin
          lit_d = 1'b0; level_d = '0;
        end
        MODE_ON: begin
          lit_d = 1'b1; level_d = PwmTop;
        end
        MODE_BREATHE: begin
          lit_d = 1'b1; level_d = ramp_lookup('0); toggle_d = item_i.now_us;
        end
        default: begin
          lit_d = 1'b1; level_d = PwmTop; toggle_d = item_i.now_us;
        end
      endcase
    end else if (mode_q == MODE_BREATHE) begin
      level_d = ramp_lookup(ramp_idx);
      phase_d = (phase_q >= PhaseLast) ? '0 : phase_q + 1'b1;
    end else if (is_toggle) begin
      if (elapsed >= tog_limit) begin
        lit_d    = !lit_q;
        level_d  = lit_q ? '0 : PwmTop;
        toggle_d = item_i.now_us;
      end
    end else if (is_pattern) begin
      if (elapsed >= pat_limit) begin
        // odd steps end dark phases, even steps end lit phases
        lit_d    = step_q[0];
        level_d  = step_q[0] ? PwmTop : '0;
        step_d   = step_q + 2'd1;
        toggle_d = item_i.now_us;
      end
    end
  end

  assign result_o.level = level_d;
  assign result_o.lit   = lit_d;

  // Commit state when the item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_OFF;
      lit_q    <= 1'b0;
      toggle_q <= '0;
      step_q   <= '0;
      phase_q  <= '0;
      level_q  <= '0;
    end else if (step_en_i) begin
      mode_q   <= mode_d;
      lit_q    <= lit_d;
      toggle_q <= toggle_d;
      step_q   <= step_d;
      phase_q  <= phase_d;
      level_q  <= level_d;
    end
  end

  a_off_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_OFF) |-> (!lit_q && level_q == '0))
    else $error("off mode drives the LED");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PhaseLast)
    else $error("breathing phase out of range");

  a_step_only_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != 2'd0) |-> (mode_q == MODE_DOUBLE || mode_q == MODE_CONNECTING))
    else $error("pattern step advanced outside a pattern mode");

  a_breathe_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en_i && item_i.op == OP_SET && item_i.new_mode == MODE_BREATHE)
      |=> (lit_q && phase_q == '0))
    else $error("breathing entry did not light the LED");

endmodule

`default_nettype wire
